// ----- hdl/scbc_pkg.sv -----
// Shared types, codes and constants of the second-chance block cache.
// No dependencies.
`default_nettype none
package scbc_pkg;
   localparam int SLOTS_DEFAULT = 32;
   localparam int SLOT_W = 6;
   localparam logic [SLOT_W-1:0] NIL = 6'd63;

   localparam logic [2:0] FN_FIND = 3'd0;
   localparam logic [2:0] FN_LOAD = 3'd1;
   localparam logic [2:0] FN_ZERO = 3'd2;
   localparam logic [2:0] FN_DIRTY = 3'd3;
   localparam logic [2:0] FN_FLUSH = 3'd4;
   localparam logic [2:0] FN_INVAL = 3'd5;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_MISS_LOAD = 3'd1;
   localparam logic [2:0] ST_MISS_ZERO = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NO_PAGE = 3'd4;
   localparam logic [2:0] ST_BAD_FILE = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;
   localparam logic [2:0] ST_ABSENT = 3'd7;

   localparam logic KIND_WB = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_req;    // capture request
      logic lookup;      // register exact-match result
      logic pop_free;    // take head of free list into victim
      logic walk_step;   // unlink fifo head, second chance or claim
      logic install;     // fill victim with request tag, push to fifo
      logic return_free; // push victim back on free list
      logic scan_step;   // flush/invalidate one slot at scan index
      logic scan_clr;
      logic mark_dirty;
      logic touch;       // set reference of hit slot
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic free_avail;
      logic fifo_avail;
      logic walk_done;   // fifo head is unreferenced: this walk step claims it
      logic victim_dirty;
      logic scan_match;  // slot at scan index matches with action
      logic scan_last;
   } sts_type;
endpackage
`default_nettype wire

// ----- hdl/scbc_datapath.sv -----
// Datapath: slot tags and flags, fifo and free-list links, lookup, scan index.
// Depends on scbc_pkg.
`default_nettype none
module scbc_datapath import scbc_pkg::*; #(
   parameter int CACHE_SLOTS = SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output      sts_type           sts,
   input  wire logic [2:0]        req_func,
   input  wire logic [7:0]        req_fd,
   input  wire logic [31:0]       req_block_num,
   output      logic [SLOT_W-1:0] hit_slot,
   output      logic [SLOT_W-1:0] victim,
   output      logic [SLOT_W-1:0] scan_idx,
   output      logic [7:0]        tag_fd_out,
   output      logic [31:0]       tag_block_out,
   output      logic [2:0]        func_q,
   output      logic [7:0]        fd_q,
   output      logic [31:0]       blk_q
);
   localparam int IW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

   logic [CACHE_SLOTS-1:0] valid_ff, valid_in, dirty_ff, dirty_in, ref_ff, ref_in;
   logic [7:0]        tfd_ff [CACHE_SLOTS];
   logic [31:0]       tblk_ff [CACHE_SLOTS];
   logic [SLOT_W-1:0] fnext_ff [CACHE_SLOTS];
   logic [SLOT_W-1:0] fprev_ff [CACHE_SLOTS];
   logic [SLOT_W-1:0] free_ff [CACHE_SLOTS];
   logic [SLOT_W-1:0] fhead_ff, ftail_ff, free_head_ff, victim_ff, scan_ff, hit_ff;
   logic [5:0] fcount_ff;
   logic hit_v_ff;
   logic [2:0] func_ff;
   logic [7:0] fd_ff;
   logic [31:0] blk_ff;

   // exact match over all slots, priority to the lowest
   logic [SLOT_W-1:0] match_idx;
   logic match_any;
   always_comb begin
      match_idx = '0;
      match_any = 1'b0;
      for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && tfd_ff[i] == fd_ff && tblk_ff[i] == blk_ff) begin
            match_idx = SLOT_W'(i);
            match_any = 1'b1;
         end
      end
   end

   logic [IW-1:0] si, hi, vi, wi;
   assign si = scan_ff[IW-1:0];
   assign hi = hit_ff[IW-1:0];
   assign vi = victim_ff[IW-1:0];
   assign wi = fhead_ff[IW-1:0];

   logic scan_hit;
   assign scan_hit = valid_ff[si] && tfd_ff[si] == fd_ff &&
                     (func_ff == FN_INVAL || dirty_ff[si]);

   assign sts.hit = hit_v_ff;
   assign sts.free_avail = free_head_ff < SLOT_W'(CACHE_SLOTS);
   assign sts.fifo_avail = fcount_ff != '0 && fhead_ff < SLOT_W'(CACHE_SLOTS);
   assign sts.walk_done = !ref_ff[wi];
   assign sts.victim_dirty = dirty_ff[vi];
   assign sts.scan_match = scan_hit;
   assign sts.scan_last = scan_ff == SLOT_W'(CACHE_SLOTS - 1);

   assign hit_slot = hit_ff;
   assign victim = victim_ff;
   assign scan_idx = scan_ff;
   assign func_q = func_ff;
   assign fd_q = fd_ff;
   assign blk_q = blk_ff;
   // tags for write-back (victim) or flush (scan)
   assign tag_fd_out = cmd.scan_step ? tfd_ff[si] : tfd_ff[vi];
   assign tag_block_out = cmd.scan_step ? tblk_ff[si] : tblk_ff[vi];

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      ref_in = ref_ff;
      if (cmd.touch) ref_in[hi] = 1'b1;
      if (cmd.mark_dirty) dirty_in[hi] = 1'b1;
      if (cmd.walk_step) begin
         // a claimed victim keeps its dirty flag for the write-back decision
         if (ref_ff[wi]) ref_in[wi] = 1'b0;
         else valid_in[wi] = 1'b0;
      end
      if (cmd.install) begin
         valid_in[vi] = 1'b1;
         dirty_in[vi] = 1'b0;
         ref_in[vi] = 1'b1;
      end
      if (cmd.return_free) dirty_in[vi] = 1'b0;
      if (cmd.scan_step && scan_hit) begin
         dirty_in[si] = 1'b0;
         if (func_ff == FN_INVAL) begin
            valid_in[si] = 1'b0;
            ref_in[si] = 1'b0;
         end
      end
   end

   // fifo unlink of a slot, used by walk and invalidate
   logic unl;
   logic [IW-1:0] us;
   logic [SLOT_W-1:0] up, uq;
   assign unl = cmd.walk_step || (cmd.scan_step && scan_hit && func_ff == FN_INVAL);
   assign us = cmd.walk_step ? wi : si;
   assign up = fprev_ff[us];
   assign uq = fnext_ff[us];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         ref_ff <= '0;
         fhead_ff <= NIL;
         ftail_ff <= NIL;
         fcount_ff <= '0;
         free_head_ff <= '0;
         scan_ff <= '0;
         hit_v_ff <= 1'b0;
         for (int i = 0; i < CACHE_SLOTS; i++) free_ff[i] <= SLOT_W'(i + 1);
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         ref_ff <= ref_in;
         if (cmd.lookup) begin
            hit_v_ff <= match_any;
            hit_ff <= match_idx;
         end
         if (cmd.scan_clr) scan_ff <= '0;
         else if (cmd.scan_step) scan_ff <= scan_ff + 1'b1;
         if (cmd.pop_free) begin
            victim_ff <= free_head_ff;
            free_head_ff <= free_ff[free_head_ff[IW-1:0]];
         end
         if (cmd.return_free || (cmd.scan_step && scan_hit && func_ff == FN_INVAL)) begin
            free_ff[cmd.return_free ? vi : si] <= free_head_ff;
            free_head_ff <= cmd.return_free ? victim_ff : scan_ff;
         end
         if (unl) begin
            // walk: re-push a referenced head at the tail
            if (cmd.walk_step && ref_ff[wi]) begin
               if (uq < SLOT_W'(CACHE_SLOTS)) begin
                  fhead_ff <= uq;
                  fprev_ff[uq[IW-1:0]] <= NIL;
                  fnext_ff[ftail_ff[IW-1:0]] <= fhead_ff;
                  fprev_ff[wi] <= ftail_ff;
                  fnext_ff[wi] <= NIL;
                  ftail_ff <= fhead_ff;
               end
            end else begin
               if (up < SLOT_W'(CACHE_SLOTS)) fnext_ff[up[IW-1:0]] <= uq;
               else fhead_ff <= uq;
               if (uq < SLOT_W'(CACHE_SLOTS)) fprev_ff[uq[IW-1:0]] <= up;
               else ftail_ff <= up;
               fcount_ff <= fcount_ff - 1'b1;
               if (cmd.walk_step) victim_ff <= fhead_ff;
            end
         end
         if (cmd.install) begin
            fnext_ff[vi] <= NIL;
            fprev_ff[vi] <= ftail_ff;
            if (ftail_ff < SLOT_W'(CACHE_SLOTS)) fnext_ff[ftail_ff[IW-1:0]] <= victim_ff;
            else fhead_ff <= victim_ff;
            ftail_ff <= victim_ff;
            fcount_ff <= fcount_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         fd_ff <= req_fd;
         blk_ff <= req_block_num;
      end
      if (cmd.install) begin
         tfd_ff[vi] <= fd_ff;
         tblk_ff[vi] <= blk_ff;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/scbc_ctrl.sv -----
// Controller: request sequencing and the result register.
// Depends on scbc_pkg.
`default_nettype none
module scbc_ctrl import scbc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic              req_file_valid,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_kind,
   output      logic [2:0]        rsp_status,
   output      logic [5:0]        rsp_slot,
   output      logic [7:0]        rsp_page_fd,
   output      logic [31:0]       rsp_page_block,
   output      logic              rsp_last,
   output      cmd_type           cmd,
   input  wire sts_type           sts,
   input  wire logic [SLOT_W-1:0] hit_slot,
   input  wire logic [SLOT_W-1:0] victim,
   input  wire logic [SLOT_W-1:0] scan_idx,
   input  wire logic [7:0]        tag_fd,
   input  wire logic [31:0]       tag_block,
   input  wire logic [2:0]        func_q,
   input  wire logic [7:0]        fd_q,
   input  wire logic [31:0]       blk_q
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_WB = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;
   localparam logic [2:0] S_SCAN = 3'd5;
   localparam logic [2:0] S_FIN = 3'd6;

   logic [2:0] state_ff, state_in;
   logic fv_ff;
   logic ov_ff;
   logic o_kind_ff, o_last_ff;
   logic [2:0] o_st_ff;
   logic [5:0] o_slot_ff;
   logic [7:0] o_fd_ff;
   logic [31:0] o_blk_ff;
   logic [2:0] fin_st_ff, fin_st_in;
   logic fin_slot_ok_ff, fin_slot_ok_in;

   logic room;
   assign room = !ov_ff || !rsp_stall;

   logic emit, e_kind, e_last;
   logic [2:0] e_st;
   logic [5:0] e_slot;
   logic [7:0] e_fd;
   logic [31:0] e_blk;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      emit = 1'b0;
      e_kind = KIND_FINAL;
      e_last = 1'b1;
      e_st = ST_DONE;
      e_slot = '0;
      e_fd = '0;
      e_blk = '0;
      fin_st_in = fin_st_ff;
      fin_slot_ok_in = fin_slot_ok_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = S_FIN;
            fin_slot_ok_in = 1'b0;
            case (func_q)
               FN_FIND: fin_st_in = ST_HIT;
               FN_LOAD, FN_ZERO: begin
                  fin_st_in = ST_HIT;
                  state_in = S_WALK;
               end
               FN_DIRTY: fin_st_in = ST_HIT;
               FN_FLUSH: begin
                  fin_st_in = ST_DONE;
                  state_in = fv_ff ? S_SCAN : S_FIN;
                  if (!fv_ff) fin_st_in = ST_BAD_FILE;
               end
               FN_INVAL: begin
                  fin_st_in = ST_DONE;
                  state_in = S_SCAN;
               end
               default: fin_st_in = ST_DONE;
            endcase
            // find and mark dirty resolve on the registered lookup in S_FIN
            if (func_q == FN_FIND || func_q == FN_DIRTY) fin_slot_ok_in = 1'b1;
         end
         S_WALK: begin
            // first cycle here for get: lookup is now registered
            if (sts.hit) begin
               fin_st_in = ST_HIT;
               fin_slot_ok_in = 1'b1;
               state_in = S_FIN;
            end else if (sts.free_avail) begin
               cmd.pop_free = 1'b1;
               state_in = S_FILL;
            end else if (!sts.fifo_avail) begin
               fin_st_in = ST_NO_PAGE;
               state_in = S_FIN;
            end else begin
               cmd.walk_step = 1'b1;
               if (sts.walk_done) state_in = S_WB;
            end
         end
         S_WB: begin
            // victim claimed; dirty flag still visible until install/return
            if (!sts.victim_dirty) state_in = S_FILL;
            else if (room) begin
               emit = 1'b1;
               e_kind = KIND_WB;
               e_last = 1'b0;
               e_st = ST_HIT;
               e_slot = victim;
               e_fd = tag_fd;
               e_blk = tag_block;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (func_q == FN_LOAD && !fv_ff) begin
               cmd.return_free = 1'b1;
               fin_st_in = ST_BAD_FILE;
            end else begin
               cmd.install = 1'b1;
               fin_st_in = (func_q == FN_LOAD) ? ST_MISS_LOAD : ST_MISS_ZERO;
               fin_slot_ok_in = 1'b1;
            end
            state_in = S_FIN;
         end
         S_SCAN: begin
            if (room || !(sts.scan_match && func_q == FN_FLUSH)) begin
               cmd.scan_step = 1'b1;
               if (sts.scan_match && func_q == FN_FLUSH) begin
                  emit = 1'b1;
                  e_kind = KIND_WB;
                  e_last = 1'b0;
                  e_st = ST_HIT;
                  e_slot = scan_idx;
                  e_fd = tag_fd;
                  e_blk = tag_block;
               end
               if (sts.scan_last) state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (room) begin
               emit = 1'b1;
               e_st = fin_st_ff;
               if (func_q == FN_FIND && !sts.hit) e_st = ST_NOT_FOUND;
               if (func_q == FN_DIRTY && !sts.hit) e_st = ST_ABSENT;
               if (fin_slot_ok_ff && (sts.hit || fin_st_ff != ST_HIT)) begin
                  e_slot = (fin_st_ff == ST_HIT) ? hit_slot : victim;
                  e_fd = fd_q;
                  e_blk = blk_q;
               end
               if (sts.hit && fin_st_ff == ST_HIT) begin
                  cmd.touch = func_q != FN_DIRTY;
                  cmd.mark_dirty = func_q == FN_DIRTY;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      fin_st_ff <= fin_st_in;
      fin_slot_ok_ff <= fin_slot_ok_in;
      if (cmd.load_req) fv_ff <= req_file_valid;
      if (emit) begin
         o_kind_ff <= e_kind;
         o_last_ff <= e_last;
         o_st_ff <= e_st;
         o_slot_ff <= e_slot;
         o_fd_ff <= e_fd;
         o_blk_ff <= e_blk;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = o_kind_ff;
   assign rsp_status = o_st_ff;
   assign rsp_slot = o_slot_ff;
   assign rsp_page_fd = o_fd_ff;
   assign rsp_page_block = o_blk_ff;
   assign rsp_last = o_last_ff;
endmodule
`default_nettype wire

// ----- hdl/second_chance_block_cache.sv -----
// Top level of the second-chance block cache tag store.
// Depends on scbc_pkg, scbc_ctrl and scbc_datapath.
//
// Usage: a request beat (func, fd, block number, file open flag) is taken on
// req_valid with req_stall low; req_stall stays high until the request's last
// result beat has been loaded into the output register. Results leave one
// beat at a time on rsp_valid/rsp_stall; rsp_last marks the final one, and
// write-back beats (kind 0) come before it.
// Sequence: find and mark dirty go from the lookup state to the final state;
// get adds the walk state on a hit, and walk and fill with a free slot. An
// eviction adds one walk step per fifo entry the second-chance walk steps over
// (at most the slot count) plus the write-back state, whether or not the
// victim is written back. Flush and invalidate scan every slot, one a cycle,
// unless a flush write-back waits on a stalled receiver; a flush of a file
// that is not open scans nothing.
// One request at a time: the next is taken once the final beat is loaded.
// Reset (synchronous): all slots invalid, fifo empty, free list in slot
// order; no clearing pass. A stalled receiver holds the result register and
// the controller waits on it before loading the next beat.
`default_nettype none
module second_chance_block_cache import scbc_pkg::*; #(
   parameter int CACHE_SLOTS = SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_fd,
   input  wire logic [31:0] req_block_num,
   input  wire logic        req_file_valid,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_kind,
   output      logic [2:0]  rsp_status,
   output      logic [5:0]  rsp_slot,
   output      logic [7:0]  rsp_page_fd,
   output      logic [31:0] rsp_page_block,
   output      logic        rsp_last
);
   cmd_type cmd;
   sts_type sts;
   logic [SLOT_W-1:0] hit_slot, victim, scan_idx;
   logic [7:0] tag_fd, fd_q;
   logic [31:0] tag_block, blk_q;
   logic [2:0] func_q;

   scbc_datapath #(.CACHE_SLOTS(CACHE_SLOTS)) u_dp (
      .clock, .reset, .cmd, .sts, .req_func, .req_fd, .req_block_num,
      .hit_slot, .victim, .scan_idx, .tag_fd_out(tag_fd), .tag_block_out(tag_block),
      .func_q, .fd_q, .blk_q
   );

   scbc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_file_valid,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_status, .rsp_slot, .rsp_page_fd,
      .rsp_page_block, .rsp_last, .cmd, .sts, .hit_slot, .victim, .scan_idx,
      .tag_fd, .tag_block, .func_q, .fd_q, .blk_q
   );

`ifndef ASSERT_OFF
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.install, cmd.return_free, cmd.pop_free, cmd.walk_step}) <= 1)
      else $error("conflicting slot list commands");
   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WB |-> !rsp_last)
      else $error("write-back beat marked last");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken before last beat");
`endif
endmodule
`default_nettype wire
